// ===== sv/spr_pkg.sv =====
// spr_pkg: shared types, codes and constants of the systematic particle resampler
// used by spr_ctrl, spr_datapath and systematic_particle_resampler; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_WEIGHT_SCALE = 2'd0;
  localparam logic [1:0] CFG_PARTICLES    = 2'd1;

  localparam logic [15:0] WEIGHT_SCALE_RESET = 16'd4096;
  localparam logic [5:0]  PARTICLES_RESET    = 6'd32;

  // log2(e) in q1.16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_MAX_RD   = 13'b0000000000010,
    ST_MAX_UPD  = 13'b0000000000100,
    ST_EXP_RD   = 13'b0000000001000,
    ST_EXP_DIFF = 13'b0000000010000,
    ST_EXP_MUL1 = 13'b0000000100000,
    ST_EXP_MUL2 = 13'b0000001000000,
    ST_EXP_ITER = 13'b0000010000000,
    ST_EXP_ACC  = 13'b0000100000000,
    ST_WALK_THR = 13'b0001000000000,
    ST_WALK_RD  = 13'b0010000000000,
    ST_WALK_MUL = 13'b0100000000000,
    ST_WALK_CMP = 13'b1000000000000
  } spr_state_e;

  typedef struct packed {
    logic load_we;
    logic run_init;
    logic log_rd;
    logic max_upd;
    logic idx_clr;
    logic idx_inc;
    logic exp_diff;
    logic exp_mul1;
    logic exp_mul2;
    logic exp_iter;
    logic exp_acc;
    logic walk_thr;
    logic cum_rd;
    logic walk_mul;
    logic cur_inc;
    logic emit;
    logic slot_inc;
  } spr_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic iter_last;
    logic advance;
    logic slot_last;
  } spr_status_t;

  // 2^-(2^-(j+1)) in q0.16
  function automatic logic [15:0] pow2_neg_frac(input logic [3:0] j);
    logic [15:0] r;
    case (j)
      4'd0:    r = 16'd46341;
      4'd1:    r = 16'd55109;
      4'd2:    r = 16'd60097;
      4'd3:    r = 16'd62757;
      4'd4:    r = 16'd64132;
      4'd5:    r = 16'd64830;
      4'd6:    r = 16'd65182;
      4'd7:    r = 16'd65359;
      4'd8:    r = 16'd65447;
      4'd9:    r = 16'd65492;
      4'd10:   r = 16'd65514;
      4'd11:   r = 16'd65525;
      4'd12:   r = 16'd65530;
      4'd13:   r = 16'd65533;
      default: r = 16'd65535;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/systematic_particle_resampler.sv =====
// systematic resampler: load items are taken in idle (busy stays low); run items do a
// max pass (read, update per entry), exp pass (read, diff, two multiplies, 16-step table
// multiply, accumulate per entry), walk (threshold, read, multiply, compare per slot;
// reread per index advance). results: one per slot as a one-cycle strobe, no stall.
// reset (rst_ni low, async) returns the sequencer to idle, clears the write pointer and
// restores weight_scale 4096 and particles_in_use 32; store contents are undefined
`timescale 1ns / 1ps
`default_nettype none
module systematic_particle_resampler #(
  parameter int MAX_PARTICLES     = 32,
  parameter int EXP_FRACTION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item channel: accepted when start is high and busy is low
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation_i,
  input  wire logic signed [31:0] log_weight_i,
  input  wire logic [15:0]        start_offset_i,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  // result strobe and fields
  output logic                    result_valid_o,
  output logic [4:0]              chosen_index_o,
  output logic [4:0]              slot_o,
  output logic                    last_o
);
  import spr_pkg::*;

  spr_cmd_t    cmd;
  spr_status_t status;

  // config writes are always taken; issue them only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // sequencer: one-hot state machine over the three passes
  spr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .status_i    (status),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  // datapath: stores, exp unit, cross-multiplied threshold compare
  spr_datapath #(
    .MAX_PARTICLES     (MAX_PARTICLES),
    .EXP_FRACTION_BITS (EXP_FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .log_weight_i   (log_weight_i),
    .start_offset_i (start_offset_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .chosen_index_o (chosen_index_o),
    .slot_o         (slot_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

// ===== sv/spr_ctrl.sv =====
// spr_ctrl: sequencer of the resampler (load, max pass, exp pass, systematic walk)
// depends on spr_pkg; drives spr_datapath through spr_cmd_t
`timescale 1ns / 1ps
`default_nettype none
module spr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire logic                 operation_i,
  input  wire spr_pkg::spr_status_t status_i,
  output logic                      busy,
  output spr_pkg::spr_cmd_t         cmd_o
);
  import spr_pkg::*;

  spr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (operation_i == OP_RUN) begin
            cmd_o.run_init = 1'b1;
            state_d = ST_MAX_RD;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_MAX_RD: begin
        cmd_o.log_rd = 1'b1;
        state_d = ST_MAX_UPD;
      end
      ST_MAX_UPD: begin
        cmd_o.max_upd = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d = ST_EXP_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = ST_MAX_RD;
        end
      end
      ST_EXP_RD: begin
        cmd_o.log_rd = 1'b1;
        state_d = ST_EXP_DIFF;
      end
      ST_EXP_DIFF: begin
        cmd_o.exp_diff = 1'b1;
        state_d = ST_EXP_MUL1;
      end
      ST_EXP_MUL1: begin
        cmd_o.exp_mul1 = 1'b1;
        state_d = ST_EXP_MUL2;
      end
      ST_EXP_MUL2: begin
        cmd_o.exp_mul2 = 1'b1;
        state_d = ST_EXP_ITER;
      end
      ST_EXP_ITER: begin
        cmd_o.exp_iter = 1'b1;
        if (status_i.iter_last) state_d = ST_EXP_ACC;
      end
      ST_EXP_ACC: begin
        cmd_o.exp_acc = 1'b1;
        if (status_i.idx_last) begin
          state_d = ST_WALK_THR;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = ST_EXP_RD;
        end
      end
      ST_WALK_THR: begin
        cmd_o.walk_thr = 1'b1;
        state_d = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        cmd_o.cum_rd = 1'b1;
        state_d = ST_WALK_MUL;
      end
      ST_WALK_MUL: begin
        cmd_o.walk_mul = 1'b1;
        state_d = ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        if (status_i.advance) begin
          cmd_o.cur_inc = 1'b1;
          state_d = ST_WALK_RD;
        end else begin
          cmd_o.emit = 1'b1;
          if (status_i.slot_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.slot_inc = 1'b1;
            state_d = ST_WALK_THR;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/spr_datapath.sv =====
// spr_datapath: weight and cumulative stores, config registers, exp unit and walk compare
// depends on spr_pkg; sequenced by spr_ctrl
`timescale 1ns / 1ps
`default_nettype none
module spr_datapath #(
  parameter int MAX_PARTICLES     = 32,
  parameter int EXP_FRACTION_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire spr_pkg::spr_cmd_t    cmd_i,
  output spr_pkg::spr_status_t      status_o,
  input  wire logic signed [31:0]   log_weight_i,
  input  wire logic [15:0]          start_offset_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  output logic                      result_valid_o,
  output logic [4:0]                chosen_index_o,
  output logic [4:0]                slot_o,
  output logic                      last_o
);
  import spr_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int EXP_W = EXP_FRACTION_BITS + 1;
  localparam int CUM_W = EXP_W + CNT_W;
  localparam int VSH_W = 17 + EXP_FRACTION_BITS;
  localparam int SUM_W = 16 + IDX_W;
  localparam int THR_W = SUM_W + CUM_W;
  localparam int LHS_W = CUM_W + CNT_W + 16;
  localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_PARTICLES);

  // config registers
  logic [15:0] scale_q;
  logic [5:0]  pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= WEIGHT_SCALE_RESET;
      pin_q   <= PARTICLES_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WEIGHT_SCALE) scale_q <= cfg_data_i;
      if (cfg_index_i == CFG_PARTICLES)    pin_q   <= cfg_data_i[5:0];
    end
  end

  // clamped particle count
  logic [CNT_W-1:0] n_cfg;
  always_comb begin
    if (pin_q == 6'd0) begin
      n_cfg = CNT_W'(1);
    end else if ({1'b0, pin_q} > 7'(MAX_PARTICLES)) begin
      n_cfg = MaxCount;
    end else begin
      n_cfg = CNT_W'(pin_q);
    end
  end

  // control registers
  logic [CNT_W-1:0] wp_q, n_q;
  logic [IDX_W-1:0] idx_q, cur_q, slot_q;
  logic [3:0]       j_q;
  logic             rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      n_q    <= MaxCount;
      idx_q  <= '0;
      cur_q  <= '0;
      slot_q <= '0;
      j_q    <= '0;
      rv_q   <= 1'b0;
    end else begin
      rv_q <= cmd_i.emit;
      if (cmd_i.load_we && (wp_q < MaxCount)) wp_q <= wp_q + CNT_W'(1);
      if (cmd_i.run_init) begin
        wp_q   <= '0;
        n_q    <= n_cfg;
        idx_q  <= '0;
        cur_q  <= '0;
        slot_q <= '0;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + IDX_W'(1);
      if (cmd_i.exp_mul2) j_q <= '0;
      else if (cmd_i.exp_iter) j_q <= j_q + 4'd1;
      if (cmd_i.cur_inc) cur_q <= cur_q + IDX_W'(1);
      if (cmd_i.slot_inc) slot_q <= slot_q + IDX_W'(1);
    end
  end

  // weight store
  logic [31:0] log_mem [MAX_PARTICLES];
  logic [31:0] log_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && (wp_q < MaxCount)) log_mem[wp_q[IDX_W-1:0]] <= log_weight_i;
    if (cmd_i.log_rd) log_rd_q <= log_mem[idx_q];
  end

  // payload registers
  logic signed [31:0] max_q;
  logic [15:0]        start_q;
  logic [32:0]        diff_q;
  logic [48:0]        arg_q;
  logic [49:0]        t_q;
  logic               zero_q;
  logic [16:0]        v_q;
  logic [CUM_W-1:0]   run_q;
  logic [CUM_W-1:0]   cum_rd_q;
  logic [THR_W-1:0]   thr_q;
  logic [CUM_W+CNT_W-1:0] lhs_q;

  logic [15:0]      frac;
  logic [5:0]       ip;
  logic [32:0]      prod;
  logic [VSH_W-1:0] shifted;
  logic [EXP_W-1:0] e_val;
  logic [CUM_W-1:0] run_d;
  logic [SUM_W-1:0] pos;

  assign frac    = t_q[43:28];
  assign ip      = t_q[49:44];
  assign prod    = 33'(v_q) * 33'(pow2_neg_frac(j_q)) + 33'd32768;
  assign shifted = {v_q, {EXP_FRACTION_BITS{1'b0}}} >> (7'd16 + {1'b0, ip});
  assign e_val   = zero_q ? '0 : shifted[EXP_W-1:0];
  assign run_d   = run_q + CUM_W'(e_val);
  assign pos     = SUM_W'(start_q) + {slot_q, 16'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init) begin
      start_q <= start_offset_i;
      run_q   <= '0;
    end
    if (cmd_i.max_upd && ((idx_q == '0) || ($signed(log_rd_q) > max_q))) max_q <= log_rd_q;
    if (cmd_i.exp_diff) diff_q <= {max_q[31], max_q} - {log_rd_q[31], log_rd_q};
    if (cmd_i.exp_mul1) arg_q <= 49'(diff_q) * 49'(scale_q);
    if (cmd_i.exp_mul2) begin
      zero_q <= (arg_q > (49'd1 << 32));
      t_q    <= 50'(arg_q[32:0]) * 50'(LOG2E_Q16);
      v_q    <= 17'd65536;
    end
    if (cmd_i.exp_iter && frac[4'd15 - j_q]) v_q <= prod[32:16];
    if (cmd_i.exp_acc) run_q <= run_d;
    if (cmd_i.walk_thr) thr_q <= THR_W'(pos) * THR_W'(run_q);
    if (cmd_i.walk_mul) lhs_q <= (CUM_W+CNT_W)'(cum_rd_q) * (CUM_W+CNT_W)'(n_q);
  end

  // cumulative store
  logic [CUM_W-1:0] cum_mem [MAX_PARTICLES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_acc) cum_mem[idx_q] <= run_d;
    if (cmd_i.cum_rd) cum_rd_q <= cum_mem[cur_q];
  end

  // status
  logic [CNT_W-1:0] n_last;
  logic [IDX_W+4:0] cur_ext, slot_ext;

  assign n_last             = n_q - CNT_W'(1);
  assign status_o.idx_last  = (CNT_W'(idx_q) == n_last);
  assign status_o.iter_last = (j_q == 4'd15);
  assign status_o.slot_last = (CNT_W'(slot_q) == n_last);
  assign status_o.advance   = (CNT_W'(cur_q) < n_last) &&
                              ({lhs_q, 16'b0} < LHS_W'(thr_q));

  assign cur_ext  = (IDX_W+5)'(cur_q);
  assign slot_ext = (IDX_W+5)'(slot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      chosen_index_o <= cur_ext[4:0];
      slot_o         <= slot_ext[4:0];
      last_o         <= status_o.slot_last;
    end
  end

  assign result_valid_o = rv_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for systematic_particle_resampler, loads and runs with
// random pacing, predicted slot picks compared in order; depends on spr_pkg and the rtl
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import spr_pkg::*;

  localparam int NP = 32;

  typedef struct packed {
    logic        op;
    logic [31:0] lw;
    logic [15:0] off;
  } req_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [4:0] slot;
    logic       last;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = 1'b0;
  logic signed [31:0] log_weight_i = '0;
  logic [15:0] start_offset_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [4:0] chosen_index_o, slot_o;
  logic last_o;

  systematic_particle_resampler dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] lw_mem [NP];
  int unsigned wr_ptr;
  logic [15:0] scale_q;
  logic [5:0]  count_q;

  req_t  pend_q[$];
  pick_t picks_q[$];
  int    errors = 0;
  int    mism = 0;
  int    gap_cnt = 0;
  int    burst_cnt = 0;

  // append one item to the pending queue
  task automatic queue_item(req_t r);
    pend_q.insert(pend_q.size(), r);
  endtask

  // exp(-diff*scale) in q.16 via table and shift
  function automatic longint unsigned exp_weight(longint unsigned diff);
    longint unsigned arg, t, v;
    int unsigned ip, fr;
    arg = diff * scale_q;
    v = 65536;
    if (arg > (64'd16 << 28)) return 0;
    t = arg * 94548;
    ip = 32'(t >> 44);
    fr = 32'((t >> 28) & 64'hFFFF);
    for (int j = 0; j < 16; j++)
      if (fr[15-j]) v = (v * pow2_neg_frac(j[3:0]) + 32768) >> 16;
    return (v << 16) >> (16 + ip);
  endfunction

  // apply one accepted item to the model, queue the slot picks of a run
  task automatic predict_item(req_t r);
    int unsigned n, cur;
    longint signed mx, w;
    longint unsigned run_sum, cum[NP], thr;
    pick_t p;
    if (r.op == OP_LOAD) begin
      if (wr_ptr < NP) begin
        lw_mem[wr_ptr] = r.lw;
        wr_ptr++;
      end
      return;
    end
    n = (count_q == 0) ? 1 : (count_q > NP) ? NP : count_q;
    mx = $signed(lw_mem[0]);
    for (int i = 1; i < n; i++) begin
      w = $signed(lw_mem[i]);
      if (w > mx) mx = w;
    end
    run_sum = 0;
    for (int i = 0; i < n; i++) begin
      run_sum += exp_weight(mx - longint'($signed(lw_mem[i])));
      cum[i] = run_sum;
    end
    cur = 0;
    for (int i = 0; i < n; i++) begin
      thr = (longint'(r.off) + (longint'(i) << 16)) * run_sum;
      while (cur < n - 1 && ((cum[cur] * n) << 16) < thr) cur++;
      p.idx = cur[4:0];
      p.slot = i[4:0];
      p.last = (i == n - 1);
      picks_q.insert(picks_q.size(), p);
    end
    wr_ptr = 0;
  endtask

  // driver: bursts and gaps, changes on falling edge
  always @(negedge clk_i) begin
    if (pend_q.size() > 0 && rst_ni) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        operation_i <= pend_q[0].op;
        log_weight_i <= pend_q[0].lw;
        start_offset_i <= pend_q[0].off;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // acceptance at rising edge, predictor update there
  always @(posedge clk_i) begin
    if (start && !busy && pend_q.size() > 0) begin
      predict_item(pend_q.pop_front());
      if (burst_cnt > 0) burst_cnt--;
      else begin
        burst_cnt = $urandom_range(0, 8);
        gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (picks_q.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected result idx %0d slot %0d", chosen_index_o, slot_o);
        mism++;
      end else begin
        pick_t e;
        e = picks_q.pop_front();
        if (e.idx !== chosen_index_o || e.slot !== slot_o || e.last !== last_o) begin
          errors++;
          if (mism < 10)
            $display("mismatch exp idx %0d slot %0d last %0d got %0d %0d %0d",
                     e.idx, e.slot, e.last, chosen_index_o, slot_o, last_o);
          mism++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pend_q.size() > 0 || picks_q.size() > 0 || start) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // register write while idle, model updated on the handshake
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_WEIGHT_SCALE) scale_q = val;
    else if (idx == CFG_PARTICLES) count_q = val[5:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_weight(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32768);
      default: return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
    endcase
  endfunction

  // one well-formed group: n loads (sometimes extra) then a run
  task automatic push_group(int n, int mode, logic [15:0] off);
    req_t r;
    int k;
    k = n + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
    if (k > NP + 2) k = NP + 2;
    for (int i = 0; i < k; i++) begin
      r.op = OP_LOAD;
      r.lw = rand_weight(mode);
      r.off = 16'($urandom());
      queue_item(r);
    end
    r.op = OP_RUN;
    r.lw = $urandom();
    r.off = off;
    queue_item(r);
  endtask

  int unsigned n_eff;
  req_t dr;

  initial begin
    scale_q = WEIGHT_SCALE_RESET;
    count_q = PARTICLES_RESET;
    wr_ptr = 0;
    for (int i = 0; i < NP; i++) lw_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme weights and offsets at small counts
    write_reg(CFG_PARTICLES, 16'd4);
    dr.op = OP_LOAD; dr.off = 16'hFFFF;
    dr.lw = 32'h7FFFFFFF; queue_item(dr);
    dr.lw = 32'h80000000; queue_item(dr);
    dr.lw = 32'h00000000; queue_item(dr);
    dr.lw = 32'hFFFF0000; queue_item(dr);
    dr.op = OP_RUN; dr.lw = 32'hFFFFFFFF; dr.off = 16'h0000; queue_item(dr);
    push_group(4, 2, 16'hFFFF);
    wait_drained();
    // zero scale, count zero acts as one
    write_reg(CFG_WEIGHT_SCALE, 16'd0);
    write_reg(CFG_PARTICLES, 16'd0);
    push_group(1, 0, 16'h8000);
    wait_drained();
    // count above max, full store with extra loads ignored
    write_reg(CFG_WEIGHT_SCALE, 16'hFFFF);
    write_reg(CFG_PARTICLES, 16'd63);
    push_group(NP, 2, 16'h1234);
    wait_drained();
    write_reg(CFG_WEIGHT_SCALE, 16'd1);
    write_reg(CFG_PARTICLES, 16'd32);
    push_group(NP, 0, 16'($urandom()));
    wait_drained();

    // random phases, each with its own settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_WEIGHT_SCALE, (ph == 0) ? 16'd4096 : 16'($urandom_range(0, 16'hFFFF)));
      n_eff = (ph == 5) ? 32 : $urandom_range(1, 12);
      write_reg(CFG_PARTICLES, 16'(n_eff));
      for (int g = 0; g < 3; g++) push_group(n_eff, $urandom_range(0, 2), 16'($urandom()));
      wait_drained();
    end
    // default scale again
    write_reg(CFG_WEIGHT_SCALE, 16'd4096);
    write_reg(CFG_PARTICLES, 16'd3);
    for (int g = 0; g < 8; g++) push_group(3, 2, 16'($urandom()));
    wait_drained();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
